[rtl/ialu_pkg.sv]
// shared types, operation codes and widths for the split-word alu
`default_nettype none
package ialu_pkg;

    localparam int unsigned Word = 32;
    localparam int unsigned Width = 64;
    localparam int unsigned DivSteps = 64;

    typedef logic [2:0] t_kind;

    localparam t_kind KindAdd = 3'd0;
    localparam t_kind KindSub = 3'd1;
    localparam t_kind KindMul = 3'd2;
    localparam t_kind KindDiv = 3'd3;
    localparam t_kind KindMod = 3'd4;
    localparam t_kind KindCmp = 3'd5;

    typedef struct packed {
        t_kind              kind;
        logic [Width-1:0]   rem;
        logic [Width-1:0]   quo;
        logic [Width-1:0]   divisor;
        logic [Width-1:0]   res;
        logic               less;
        logic               equal;
        logic               bzero;
    } t_div_item;

endpackage
`default_nettype wire

[rtl/int64_split_word_alu.sv]
// top level of the pipelined 64-bit split-word alu
// each operand arrives as a signed upper word and an unsigned lower word
// input channel: i_valid with o_stall, item taken when i_valid and !o_stall
// output channel: o_valid with i_stall, item taken when o_valid and !i_stall
// kinds: add, sub, mul wrap mod 2^64; div and mod unsigned; compare only
// a zero divisor gives a zero result and raises o_div_zero
// o_a_less and o_a_equal come with every result
// pipeline: an operand stage, a product stage, the 64 quotient-bit stages of the
// divider and the output register, in that order, for every kind of operation
// throughput: one item per cycle; empty stages fill while the receiver stalls,
// so the input stalls only once every stage holds an item
// reset clears all stage valid bits; the pipeline is empty after reset
`default_nettype none
module int64_split_word_alu (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_kind,
    input  wire logic signed [31:0] i_a_upper,
    input  wire logic [31:0]        i_a_lower,
    input  wire logic signed [31:0] i_b_upper,
    input  wire logic [31:0]        i_b_lower,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_res_upper,
    output logic [31:0]             o_res_lower,
    output logic                    o_a_less,
    output logic                    o_a_equal,
    output logic                    o_div_zero
);

    localparam int unsigned Steps = ialu_pkg::DivSteps;

    // stage one registers
    logic                  r_v1;
    ialu_pkg::t_kind       r_kind1;
    logic [63:0]           r_a1;
    logic [63:0]           r_b1;
    logic [63:0]           r_addsub1;
    logic [63:0]           r_p0;
    logic [31:0]           r_p1;
    logic [31:0]           r_p2;
    logic                  r_less1;
    logic                  r_equal1;

    ialu_pkg::t_kind       f_kind;
    logic [63:0]           f_addsub;
    logic [63:0]           f_p0;
    logic [31:0]           f_p1;
    logic [31:0]           f_p2;
    logic                  f_less;
    logic                  f_equal;

    // stage two and divider stages
    logic                  r_v2;
    ialu_pkg::t_div_item   r_item2;
    ialu_pkg::t_div_item   n_item2;
    logic                  r_dv  [Steps];
    logic                  dv_in [Steps];
    ialu_pkg::t_div_item   r_dd  [Steps];
    ialu_pkg::t_div_item   n_dd  [Steps];
    logic                  en_d  [Steps];

    // output stage
    logic                  r_vo;
    logic [63:0]           r_res;
    logic                  r_less;
    logic                  r_equal;
    logic                  r_zero;
    logic [63:0]           n_res;
    logic                  n_zero;

    logic                  en_o;
    logic                  en2;
    logic                  en1;

    ialu_front u_front (
        .i_kind   (i_kind),
        .i_a      ({i_a_upper, i_a_lower}),
        .i_b      ({i_b_upper, i_b_lower}),
        .o_kind   (f_kind),
        .o_addsub (f_addsub),
        .o_p0     (f_p0),
        .o_p1     (f_p1),
        .o_p2     (f_p2),
        .o_less   (f_less),
        .o_equal  (f_equal)
    );

    // per-stage enables, bubbles fill ahead of a stall
    always_comb begin
        en_o = !r_vo || !i_stall;
        en_d[Steps-1] = !r_dv[Steps-1] || en_o;
        for (int k = Steps - 2; k >= 0; k--) begin
            en_d[k] = !r_dv[k] || en_d[k+1];
        end
        en2 = !r_v2 || en_d[0];
        en1 = !r_v1 || en2;
    end

    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
        if (en1) begin
            r_kind1   <= f_kind;
            r_a1      <= {i_a_upper, i_a_lower};
            r_b1      <= {i_b_upper, i_b_lower};
            r_addsub1 <= f_addsub;
            r_p0      <= f_p0;
            r_p1      <= f_p1;
            r_p2      <= f_p2;
            r_less1   <= f_less;
            r_equal1  <= f_equal;
        end
    end

    always_comb begin
        n_item2.kind    = r_kind1;
        n_item2.rem     = '0;
        n_item2.quo     = r_a1;
        n_item2.divisor = r_b1;
        n_item2.less    = r_less1;
        n_item2.equal   = r_equal1;
        n_item2.bzero   = r_b1 == 64'd0;
        if (r_kind1 == ialu_pkg::KindMul) begin
            n_item2.res = r_p0 + {r_p1 + r_p2, 32'd0};
        end else begin
            n_item2.res = r_addsub1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2) begin
            r_item2 <= n_item2;
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_div
        if (k == 0) begin : g_first
            ialu_div_step u_step (.i_item(r_item2), .o_item(n_dd[k]));
            assign dv_in[k] = r_v2;
        end else begin : g_next
            ialu_div_step u_step (.i_item(r_dd[k-1]), .o_item(n_dd[k]));
            assign dv_in[k] = r_dv[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (en_d[k]) begin
                r_dv[k] <= dv_in[k];
            end
            if (en_d[k]) begin
                r_dd[k] <= n_dd[k];
            end
        end
    end

    always_comb begin
        n_zero = 1'b0;
        case (r_dd[Steps-1].kind)
            ialu_pkg::KindAdd, ialu_pkg::KindSub, ialu_pkg::KindMul: begin
                n_res = r_dd[Steps-1].res;
            end
            ialu_pkg::KindDiv: begin
                n_zero = r_dd[Steps-1].bzero;
                n_res  = n_zero ? 64'd0 : r_dd[Steps-1].quo;
            end
            ialu_pkg::KindMod: begin
                n_zero = r_dd[Steps-1].bzero;
                n_res  = n_zero ? 64'd0 : r_dd[Steps-1].rem;
            end
            default: begin
                n_res = 64'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en_o) begin
            r_vo <= r_dv[Steps-1];
        end
        if (en_o) begin
            r_res   <= n_res;
            r_less  <= r_dd[Steps-1].less;
            r_equal <= r_dd[Steps-1].equal;
            r_zero  <= n_zero;
        end
    end

    assign o_valid     = r_vo;
    assign o_res_upper = r_res[63:32];
    assign o_res_lower = r_res[31:0];
    assign o_a_less    = r_less;
    assign o_a_equal   = r_equal;
    assign o_div_zero  = r_zero;

`ifndef ASSERT_OFF
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (i_stall && r_vo))
        else $error("input stalled without a stalled result");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |-> (r_res == 64'd0))
        else $error("zero divisor with nonzero result");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted item lost at first stage");

    a_equal_not_less: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_a_less && o_a_equal))
        else $error("operands both less and equal");
`endif

endmodule
`default_nettype wire

[rtl/ialu_front.sv]
// first stage arithmetic: add, subtract, compare and multiply partial products
`default_nettype none
module ialu_front (
    input  wire ialu_pkg::t_kind  i_kind,
    input  wire logic [63:0]      i_a,
    input  wire logic [63:0]      i_b,
    output ialu_pkg::t_kind       o_kind,
    output logic [63:0]           o_addsub,
    output logic [63:0]           o_p0,
    output logic [31:0]           o_p1,
    output logic [31:0]           o_p2,
    output logic                  o_less,
    output logic                  o_equal
);

    logic [31:0] a_lo;
    logic [31:0] b_lo;

    assign a_lo = i_a[31:0];
    assign b_lo = i_b[31:0];

    always_comb begin
        if (i_kind == ialu_pkg::KindSub) begin
            o_addsub = i_a - i_b;
        end else begin
            o_addsub = i_a + i_b;
        end
    end

    assign o_kind  = i_kind;
    assign o_p0    = {32'd0, a_lo} * {32'd0, b_lo};
    assign o_p1    = a_lo * i_b[63:32];
    assign o_p2    = i_a[63:32] * b_lo;
    assign o_less  = $signed(i_a) < $signed(i_b);
    assign o_equal = i_a == i_b;

endmodule
`default_nettype wire

[rtl/ialu_div_step.sv]
// one restoring division step, one quotient bit
`default_nettype none
module ialu_div_step (
    input  wire ialu_pkg::t_div_item i_item,
    output ialu_pkg::t_div_item      o_item
);

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    assign trial = {i_item.rem, i_item.quo[63]};
    assign diff  = trial - {1'b0, i_item.divisor};
    assign ge    = !diff[64];

    always_comb begin
        o_item     = i_item;
        o_item.rem = ge ? diff[63:0] : trial[63:0];
        o_item.quo = {i_item.quo[62:0], ge};
    end

endmodule
`default_nettype wire
